// ===== hdl/rhp_pkg.sv =====
`timescale 1ns / 1ps

package rhp_pkg;

   // field walk limits
   localparam logic [4:0] FieldCount      = 5'd20;
   localparam int         ExtBitInTopByte = 5;    // bit 29 of a present word, seen in byte 3

   // configuration port
   localparam int          CsrAddrWidth  = 3;
   localparam int          CsrDataWidth  = 32;
   localparam logic        CsrMaxLength  = 1'b0;  // register index of max_length
   localparam logic [15:0] MaxLengthInit = 16'd255;

   // radiotap field numbers that are captured
   localparam logic [4:0] FieldFlags   = 5'd1;
   localparam logic [4:0] FieldRate    = 5'd2;
   localparam logic [4:0] FieldChannel = 5'd3;
   localparam logic [4:0] FieldMcs     = 5'd19;

   typedef struct packed {
      logic [4:0] number;
      logic [3:0] bytes_left;
   } rhp_field_type;

   typedef struct packed {
      logic        length_ok;
      logic [15:0] header_length;
      logic [31:0] present_flags;
      logic [7:0]  frame_flags;
      logic [7:0]  data_rate;
      logic [15:0] frequency;
      logic [15:0] channel_flags;
      logic [7:0]  mcs_known;
      logic [7:0]  mcs_flags;
      logic [7:0]  mcs_index;
   } rhp_result_type;

   // size in bytes of each field, packed with no padding
   function automatic logic [3:0] field_size(input logic [4:0] number);
      logic [3:0] size;
      case (number)
         5'd0:    size = 4'd8;
         5'd1:    size = 4'd1;
         5'd2:    size = 4'd1;
         5'd3:    size = 4'd4;
         5'd4:    size = 4'd2;
         5'd5:    size = 4'd1;
         5'd6:    size = 4'd1;
         5'd7:    size = 4'd2;
         5'd8:    size = 4'd2;
         5'd9:    size = 4'd2;
         5'd10:   size = 4'd1;
         5'd11:   size = 4'd1;
         5'd12:   size = 4'd1;
         5'd13:   size = 4'd1;
         5'd14:   size = 4'd2;
         5'd15:   size = 4'd2;
         5'd16:   size = 4'd1;
         5'd17:   size = 4'd1;
         5'd18:   size = 4'd8;
         5'd19:   size = 4'd3;
         default: size = 4'd0;
      endcase
      return size;
   endfunction

   // first present field at or after 'from'; walk done when none is left
   function automatic rhp_field_type seek_field(input logic [19:0] present,
                                                input logic [4:0]  from);
      rhp_field_type result;
      result.number     = FieldCount;
      result.bytes_left = 4'd0;
      for (int i = 19; i >= 0; i--) begin
         if (present[i] && (5'(i) >= from)) begin
            result.number     = 5'(i);
            result.bytes_left = field_size(5'(i));
         end
      end
      return result;
   endfunction

endpackage

// ===== hdl/rhp_ifs.sv =====
`timescale 1ns / 1ps

// input byte channel
interface rhp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// parse result channel
interface rhp_rsp_if;
   logic        valid;
   logic        ready;
   logic        length_ok;
   logic [15:0] header_length;
   logic [31:0] present_flags;
   logic [7:0]  frame_flags;
   logic [7:0]  data_rate;
   logic [15:0] frequency;
   logic [15:0] channel_flags;
   logic [7:0]  mcs_known;
   logic [7:0]  mcs_flags;
   logic [7:0]  mcs_index;

   modport source (output valid, output length_ok, output header_length,
                   output present_flags, output frame_flags, output data_rate,
                   output frequency, output channel_flags, output mcs_known,
                   output mcs_flags, output mcs_index, input ready);
   modport sink   (input valid, input length_ok, input header_length,
                   input present_flags, input frame_flags, input data_rate,
                   input frequency, input channel_flags, input mcs_known,
                   input mcs_flags, input mcs_index, output ready);
endinterface

// ===== hdl/radiotap_header_parser_unit.sv =====
`timescale 1ns / 1ps
// the result is registered: it is valid in the cycle after the byte marked last is accepted
// throughput: one byte per cycle; the parse state updates in the accept cycle
// a byte is accepted while the result register is empty or being taken
// reset (synchronous, active high) clears packet state, stored values and
// the result valid flag, and sets max_length to 255

module radiotap_header_parser_unit (
   input  logic                              clock,
   input  logic                              reset,
   rhp_req_if.sink                           req,
   rhp_rsp_if.source                         rsp,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rhp_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  logic [rhp_pkg::CsrDataWidth-1:0]  csr_pwdata,
   output logic [rhp_pkg::CsrDataWidth-1:0]  csr_prdata,
   output logic                              csr_pready
);
   import rhp_pkg::*;

   // configuration
   logic [15:0] max_length_ff;

   // packet state
   logic [15:0] byte_position_ff, byte_position_in;
   logic        in_present_ff, in_present_in;
   logic [31:0] present_shift_ff, present_shift_in;
   logic [4:0]  field_number_ff, field_number_in;
   logic [3:0]  field_left_ff, field_left_in;
   logic        length_accepted_ff, length_accepted_in;

   // stored values
   logic [15:0] saved_length_ff, saved_length_in;
   logic [31:0] saved_present_ff, saved_present_in;
   logic [7:0]  saved_flags_ff, saved_flags_in;
   logic [7:0]  saved_rate_ff, saved_rate_in;
   logic [15:0] saved_frequency_ff, saved_frequency_in;
   logic [15:0] saved_channel_flags_ff, saved_channel_flags_in;
   logic [23:0] saved_mcs_ff, saved_mcs_in;

   // result register
   logic           rsp_valid_ff;
   rhp_result_type result_ff, result_in;

   logic        req_accept;
   logic        csr_write;
   logic [15:0] new_length;
   logic [31:0] present_word;
   logic [3:0]  field_offset;
   logic [3:0]  left_after;
   rhp_field_type next_field;

   assign req_accept = req.valid && req.ready;
   assign req.ready  = !rsp_valid_ff || rsp.ready;

   // configuration port
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CsrMaxLength) ?
                       {{(CsrDataWidth-16){1'b0}}, max_length_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= MaxLengthInit;
      end else if (csr_write && (csr_paddr[2] == CsrMaxLength)) begin
         max_length_ff <= csr_pwdata[15:0];
      end
   end

   // byte step: header length, present words, then the field walk
   always_comb begin
      byte_position_in       = byte_position_ff;
      in_present_in          = in_present_ff;
      present_shift_in       = present_shift_ff;
      field_number_in        = field_number_ff;
      field_left_in          = field_left_ff;
      length_accepted_in     = length_accepted_ff;
      saved_length_in        = saved_length_ff;
      saved_present_in       = saved_present_ff;
      saved_flags_in         = saved_flags_ff;
      saved_rate_in          = saved_rate_ff;
      saved_frequency_in     = saved_frequency_ff;
      saved_channel_flags_in = saved_channel_flags_ff;
      saved_mcs_in           = saved_mcs_ff;
      new_length             = {req.data_byte, present_shift_ff[7:0]};
      present_word           = present_shift_ff;
      field_offset           = field_size(field_number_ff) - field_left_ff;
      left_after             = field_left_ff - 4'd1;
      next_field             = '0;

      if (byte_position_ff == 16'd2) begin
         present_shift_in = {24'd0, req.data_byte};
      end else if (byte_position_ff == 16'd3) begin
         present_shift_in = '0;
         if (new_length <= max_length_ff) begin
            length_accepted_in = 1'b1;
            saved_length_in    = new_length;
            in_present_in      = 1'b1;
         end
      end else if ((byte_position_ff >= 16'd4) && in_present_ff) begin
         // first present word is assembled, later ones only checked for extension
         if (byte_position_ff <= 16'd7) begin
            present_word     = present_shift_ff |
                               (32'(req.data_byte) << {byte_position_ff[1:0], 3'b000});
            present_shift_in = present_word;
            if (byte_position_ff == 16'd7) begin
               saved_present_in = present_word;
            end
         end
         if ((byte_position_ff[1:0] == 2'd3) && !req.data_byte[ExtBitInTopByte]) begin
            in_present_in   = 1'b0;
            next_field      = seek_field(present_word[19:0], 5'd0);
            field_number_in = next_field.number;
            field_left_in   = next_field.bytes_left;
         end
      end else if (length_accepted_ff && (byte_position_ff >= 16'd8) &&
                   (field_number_ff < FieldCount) && (field_left_ff != 4'd0)) begin
         // capture bytes of the fields that are kept
         case (field_number_ff)
            FieldFlags: saved_flags_in = req.data_byte;
            FieldRate:  saved_rate_in  = req.data_byte;
            FieldChannel: begin
               case (field_offset[1:0])
                  2'd0:    saved_frequency_in[7:0]      = req.data_byte;
                  2'd1:    saved_frequency_in[15:8]     = req.data_byte;
                  2'd2:    saved_channel_flags_in[7:0]  = req.data_byte;
                  default: saved_channel_flags_in[15:8] = req.data_byte;
               endcase
            end
            FieldMcs: begin
               case (field_offset)
                  4'd0:    saved_mcs_in[7:0]   = req.data_byte;
                  4'd1:    saved_mcs_in[15:8]  = req.data_byte;
                  4'd2:    saved_mcs_in[23:16] = req.data_byte;
                  default: saved_mcs_in        = saved_mcs_ff;
               endcase
            end
            default: saved_mcs_in = saved_mcs_ff;
         endcase
         field_left_in = left_after;
         if (left_after == 4'd0) begin
            next_field      = seek_field(present_shift_ff[19:0], field_number_ff + 5'd1);
            field_number_in = next_field.number;
            field_left_in   = next_field.bytes_left;
         end
      end

      if (byte_position_ff != 16'hFFFF) begin
         byte_position_in = byte_position_ff + 16'd1;
      end

      // result as seen after this byte
      result_in.length_ok     = length_accepted_in;
      result_in.header_length = saved_length_in;
      result_in.present_flags = saved_present_in;
      result_in.frame_flags   = saved_flags_in;
      result_in.data_rate     = saved_rate_in;
      result_in.frequency     = saved_frequency_in;
      result_in.channel_flags = saved_channel_flags_in;
      result_in.mcs_known     = saved_mcs_in[7:0];
      result_in.mcs_flags     = saved_mcs_in[15:8];
      result_in.mcs_index     = saved_mcs_in[23:16];
   end

   // state registers; packet state clears after the last byte
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff       <= '0;
         in_present_ff          <= 1'b0;
         present_shift_ff       <= '0;
         field_number_ff        <= '0;
         field_left_ff          <= '0;
         length_accepted_ff     <= 1'b0;
         saved_length_ff        <= '0;
         saved_present_ff       <= '0;
         saved_flags_ff         <= '0;
         saved_rate_ff          <= '0;
         saved_frequency_ff     <= '0;
         saved_channel_flags_ff <= '0;
         saved_mcs_ff           <= '0;
      end else if (req_accept) begin
         saved_length_ff        <= saved_length_in;
         saved_present_ff       <= saved_present_in;
         saved_flags_ff         <= saved_flags_in;
         saved_rate_ff          <= saved_rate_in;
         saved_frequency_ff     <= saved_frequency_in;
         saved_channel_flags_ff <= saved_channel_flags_in;
         saved_mcs_ff           <= saved_mcs_in;
         if (req.last_byte) begin
            byte_position_ff   <= '0;
            in_present_ff      <= 1'b0;
            present_shift_ff   <= '0;
            field_number_ff    <= '0;
            field_left_ff      <= '0;
            length_accepted_ff <= 1'b0;
         end else begin
            byte_position_ff   <= byte_position_in;
            in_present_ff      <= in_present_in;
            present_shift_ff   <= present_shift_in;
            field_number_ff    <= field_number_in;
            field_left_ff      <= field_left_in;
            length_accepted_ff <= length_accepted_in;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept && req.last_byte) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && req.last_byte) begin
         result_ff <= result_in;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.length_ok     = result_ff.length_ok;
   assign rsp.header_length = result_ff.header_length;
   assign rsp.present_flags = result_ff.present_flags;
   assign rsp.frame_flags   = result_ff.frame_flags;
   assign rsp.data_rate     = result_ff.data_rate;
   assign rsp.frequency     = result_ff.frequency;
   assign rsp.channel_flags = result_ff.channel_flags;
   assign rsp.mcs_known     = result_ff.mcs_known;
   assign rsp.mcs_flags     = result_ff.mcs_flags;
   assign rsp.mcs_index     = result_ff.mcs_index;

endmodule

// ===== hdl/rhp_checker.sv =====
`timescale 1ns / 1ps

module rhp_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_last_byte,
   input logic rsp_valid,
   input logic rsp_ready
);

   // result register is empty right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a result that waits is not dropped
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("stalled result dropped");

   // a new result only follows an accepted last byte
   assert property (@(posedge clock) disable iff (reset)
                    $rose(rsp_valid) |-> $past(req_valid && req_ready && req_last_byte))
      else $error("result without last byte");

   // an inner byte never makes a result
   assert property (@(posedge clock) disable iff (reset)
                    !rsp_valid && req_valid && req_ready && !req_last_byte |=> !rsp_valid)
      else $error("result on inner byte");

endmodule

bind radiotap_header_parser_unit rhp_checker u_rhp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .req_last_byte (req.last_byte),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import rhp_pkg::*;

   localparam int ClockPeriod = 4;
   localparam int ResetCycles = 12;
   localparam int StallLimit  = 2000;
   localparam int HoldCycles  = 400;
   localparam int MaxGap      = 12;
   localparam int DrainCycles = 4;
   localparam int MaxReports  = 10;
   localparam int DirectedLen = 24;
   localparam logic [CsrAddrWidth-1:0] MaxLengthAddr = CsrAddrWidth'(4 * CsrMaxLength);

   // bytes per radiotap field 0..19, packed back to back
   localparam logic [0:19][3:0] RtFieldBytes = {
      4'd8, 4'd1, 4'd1, 4'd4, 4'd2, 4'd1, 4'd1, 4'd2, 4'd2, 4'd2,
      4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd2, 4'd1, 4'd1, 4'd8, 4'd3
   };

   // values that can be read straight off the header bytes
   localparam rhp_result_type AfterResetView = '0;
   localparam rhp_result_type NoCheck        = '0;
   localparam rhp_result_type FullHeaderView = '{
      length_ok: 1'b1, header_length: 16'd17, present_flags: 32'h0008_000E,
      frame_flags: 8'h10, data_rate: 8'h6C, frequency: 16'h0985,
      channel_flags: 16'h00A0, mcs_known: 8'h07, mcs_flags: 8'h21, mcs_index: 8'hFF
   };
   localparam rhp_result_type KeptView = '{
      length_ok: 1'b0, header_length: 16'd17, present_flags: 32'h0008_000E,
      frame_flags: 8'h10, data_rate: 8'h6C, frequency: 16'h0985,
      channel_flags: 16'h00A0, mcs_known: 8'h07, mcs_flags: 8'h21, mcs_index: 8'hFF
   };

   typedef struct packed {
      logic [7:0]     data;
      logic           last;
      logic           pinned;
      rhp_result_type want;
   } script_row_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } capture_byte_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [CsrAddrWidth-1:0] csr_paddr;
   logic [CsrDataWidth-1:0] csr_pwdata;
   logic [CsrDataWidth-1:0] csr_prdata;
   logic        csr_pready;

   rhp_req_if req_ch ();
   rhp_rsp_if rsp_ch ();

   radiotap_header_parser_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #(ClockPeriod / 2) clock = ~clock;

   // parser state mirrored on the testbench side
   logic [15:0]    cfg_max_len;
   logic [15:0]    pkt_pos;
   logic           walking_present;
   logic [31:0]    present_acc;
   logic [4:0]     cur_field;
   logic [3:0]     field_left;
   logic           len_taken;
   rhp_result_type stored;

   rhp_result_type   parse_results[$];
   capture_byte_type packet_bytes[$];
   script_row_type   directed_script [DirectedLen];

   int error_count     = 0;
   int results_checked = 0;
   int items_sent      = 0;
   int packets_sent    = 0;
   int settings_used   = 0;
   int hold_requests   = 0;
   int burst_left      = 0;
   int idle_cycles     = 0;

   function automatic void clear_packet();
      pkt_pos         = '0;
      walking_present = 1'b0;
      present_acc     = '0;
      cur_field       = '0;
      field_left      = '0;
      len_taken       = 1'b0;
   endfunction

   // first field marked present at or after first_candidate
   function automatic void next_present_field(input int first_candidate);
      int n;
      cur_field  = FieldCount;
      field_left = '0;
      for (n = first_candidate; n < int'(FieldCount); n++) begin
         if (present_acc[n] && cur_field == FieldCount) begin
            cur_field  = 5'(n);
            field_left = RtFieldBytes[n];
         end
      end
   endfunction

   // advance the parse by one byte; returns 1 with the result on the last byte
   function automatic logic parse_byte(input logic [7:0] d, input logic last,
                                       output rhp_result_type res);
      logic [15:0] len;
      int          off;
      res = '0;
      if (pkt_pos == 16'd2) begin
         present_acc = {24'd0, d};
      end else if (pkt_pos == 16'd3) begin
         len         = {d, present_acc[7:0]};
         present_acc = '0;
         if (len <= cfg_max_len) begin
            len_taken            = 1'b1;
            stored.header_length = len;
            walking_present      = 1'b1;
         end
      end else if (pkt_pos >= 16'd4 && walking_present) begin
         if (pkt_pos <= 16'd7) begin
            present_acc[8*pkt_pos[1:0] +: 8] = d;
            if (pkt_pos == 16'd7) stored.present_flags = present_acc;
         end
         // top byte of a word without the extension bit ends the bitmap
         if (pkt_pos[1:0] == 2'd3 && !d[ExtBitInTopByte]) begin
            walking_present = 1'b0;
            next_present_field(0);
         end
      end else if (len_taken && pkt_pos >= 16'd8 && cur_field < FieldCount
                   && field_left != 4'd0) begin
         off = int'(RtFieldBytes[cur_field]) - int'(field_left);
         case (cur_field)
            FieldFlags: stored.frame_flags = d;
            FieldRate:  stored.data_rate = d;
            FieldChannel: begin
               case (off)
                  0:       stored.frequency[7:0] = d;
                  1:       stored.frequency[15:8] = d;
                  2:       stored.channel_flags[7:0] = d;
                  default: stored.channel_flags[15:8] = d;
               endcase
            end
            FieldMcs: begin
               case (off)
                  0:       stored.mcs_known = d;
                  1:       stored.mcs_flags = d;
                  default: stored.mcs_index = d;
               endcase
            end
            default: ;
         endcase
         field_left = field_left - 4'd1;
         if (field_left == 4'd0) next_present_field(int'(cur_field) + 1);
      end
      if (pkt_pos != 16'hFFFF) pkt_pos = pkt_pos + 16'd1;
      if (!last) return 1'b0;
      res           = stored;
      res.length_ok = len_taken;
      clear_packet();
      return 1'b1;
   endfunction

   function automatic void note_error(input string what);
      error_count++;
      if (error_count <= MaxReports) $display("[%0t] %s", $realtime, what);
   endfunction

   function automatic void compare_field(input string name, input logic [31:0] got,
                                         input logic [31:0] want);
      if (got !== want) begin
         error_count++;
         if (error_count <= MaxReports)
            $display("[%0t] mismatch on %s: expected %0h, got %0h",
                     $realtime, name, want, got);
      end
   endfunction

   function automatic void push_byte(input logic [7:0] d);
      capture_byte_type cb;
      cb.data = d;
      cb.last = 1'b0;
      packet_bytes.push_back(cb);
   endfunction

   // mostly well-formed headers with random content, some noise and cut-offs
   function automatic void make_random_packet();
      logic [31:0] word;
      logic [31:0] ext;
      logic [15:0] hdr_len;
      int          ext_words;
      int          field_total;
      int          cut;
      int          n;
      int          k;
      packet_bytes.delete();
      if ($urandom_range(0, 4) == 0) begin
         n = $urandom_range(1, 12);
         repeat (n) push_byte(8'($urandom));
      end else begin
         word       = $urandom;
         word[19:0] = word[19:0] & 20'($urandom);
         if ($urandom_range(0, 1) == 1) word[19:0] = word[19:0] | 20'h8000E;
         ext_words = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
         word[29]  = (ext_words != 0);
         field_total = 0;
         for (n = 0; n < 20; n++) if (word[n]) field_total += int'(RtFieldBytes[n]);
         hdr_len = 16'(8 + 4 * ext_words + field_total);
         case ($urandom_range(0, 7))
            0:       hdr_len = '0;
            1:       hdr_len = 16'($urandom);
            default: ;
         endcase
         push_byte(8'($urandom));
         push_byte(8'($urandom));
         push_byte(hdr_len[7:0]);
         push_byte(hdr_len[15:8]);
         for (k = 0; k < 4; k++) push_byte(word[8*k +: 8]);
         for (n = 1; n <= ext_words; n++) begin
            ext     = $urandom;
            ext[29] = (n < ext_words);
            for (k = 0; k < 4; k++) push_byte(ext[8*k +: 8]);
         end
         n = field_total + $urandom_range(0, 4);
         repeat (n) push_byte(8'($urandom));
      end
      if ($urandom_range(0, 6) == 0) begin
         cut = $urandom_range(1, packet_bytes.size());
         while (packet_bytes.size() > cut) void'(packet_bytes.pop_back());
      end
      packet_bytes[packet_bytes.size() - 1].last = 1'b1;
   endfunction

   // offer one byte after an optional gap; record the parse on acceptance
   task automatic send_item(input logic [7:0] data, input logic last,
                            input logic pinned, input rhp_result_type want);
      rhp_result_type predicted;
      int             gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MaxGap);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= data;
      req_ch.last_byte <= last;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
      if (parse_byte(data, last, predicted)) begin
         parse_results.push_back(pinned ? want : predicted);
         packets_sent++;
      end
   endtask

   task automatic send_packet();
      int i;
      for (i = 0; i < packet_bytes.size(); i++)
         send_item(packet_bytes[i].data, packet_bytes[i].last, 1'b0, NoCheck);
   endtask

   task automatic run_random(input int target, input bit with_hold);
      int sent;
      sent = 0;
      if (with_hold) hold_requests++;
      while (sent < target) begin
         make_random_packet();
         send_packet();
         sent += packet_bytes.size();
      end
   endtask

   // stop offering and wait for every expected result
   task automatic settle();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      while (parse_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic set_max_length(input logic [15:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= MaxLengthAddr;
      csr_pwdata  <= CsrDataWidth'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      cfg_max_len = value;
      settings_used++;
   endtask

   // stimulus and run control
   initial begin : stimulus
      int i;
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.data_byte <= '0;
      req_ch.last_byte <= 1'b0;
      csr_psel         <= 1'b0;
      csr_penable      <= 1'b0;
      csr_pwrite       <= 1'b0;
      csr_paddr        <= '0;
      csr_pwdata       <= '0;
      cfg_max_len = MaxLengthInit;
      stored      = '0;
      clear_packet();

      directed_script = '{
         // one-byte packet straight after reset
         '{8'hFF, 1'b1, 1'b1, AfterResetView},
         // length 17, flags, rate, channel and mcs present
         '{8'h00, 1'b0, 1'b0, NoCheck}, '{8'h00, 1'b0, 1'b0, NoCheck},
         '{8'h11, 1'b0, 1'b0, NoCheck}, '{8'h00, 1'b0, 1'b0, NoCheck},
         '{8'h0E, 1'b0, 1'b0, NoCheck}, '{8'h00, 1'b0, 1'b0, NoCheck},
         '{8'h08, 1'b0, 1'b0, NoCheck}, '{8'h00, 1'b0, 1'b0, NoCheck},
         '{8'h10, 1'b0, 1'b0, NoCheck}, '{8'h6C, 1'b0, 1'b0, NoCheck},
         '{8'h85, 1'b0, 1'b0, NoCheck}, '{8'h09, 1'b0, 1'b0, NoCheck},
         '{8'hA0, 1'b0, 1'b0, NoCheck}, '{8'h00, 1'b0, 1'b0, NoCheck},
         '{8'h07, 1'b0, 1'b0, NoCheck}, '{8'h21, 1'b0, 1'b0, NoCheck},
         '{8'hFF, 1'b1, 1'b1, FullHeaderView},
         // packet ends before the length is complete
         '{8'h00, 1'b0, 1'b0, NoCheck}, '{8'h01, 1'b1, 1'b1, KeptView},
         // length 0xffff is over max_length, stored values are kept
         '{8'h00, 1'b0, 1'b0, NoCheck}, '{8'h00, 1'b0, 1'b0, NoCheck},
         '{8'hFF, 1'b0, 1'b0, NoCheck}, '{8'hFF, 1'b1, 1'b1, KeptView}
      };

      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_max_length(MaxLengthInit);
      for (i = 0; i < DirectedLen; i++)
         send_item(directed_script[i].data, directed_script[i].last,
                   directed_script[i].pinned, directed_script[i].want);
      run_random(200, 1'b1);
      settle();

      // nothing but a zero length passes
      set_max_length(16'd0);
      run_random(120, 1'b0);
      settle();

      // every length passes
      set_max_length(16'hFFFF);
      run_random(150, 1'b0);
      settle();

      set_max_length(16'($urandom_range(12, 48)));
      run_random(140, 1'b1);
      settle();

      set_max_length(16'($urandom));
      run_random(140, 1'b0);
      settle();

      $display("run covered %0d bytes in %0d packets under %0d max_length settings",
               items_sent, packets_sent, settings_used);
      $display("%0d results checked, %0d errors", results_checked, error_count);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // result receiver: changing stall modes plus requested long hold-offs
   initial begin : rsp_stall_pattern
      int mode;
      int left;
      int hold_left;
      int served;
      mode      = 0;
      left      = 0;
      hold_left = 0;
      served    = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != served) begin
            served    = hold_requests;
            hold_left = HoldCycles;
         end
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(5, 60);
         end
         left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            case (mode)
               0:       rsp_ch.ready <= 1'b1;
               1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
               2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ch.ready <= (left % 3 == 0);
            endcase
         end
      end
   end

   // compare each taken result with the oldest expected one
   always @(posedge clock) begin : result_checker
      rhp_result_type got;
      rhp_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{rsp_ch.length_ok, rsp_ch.header_length, rsp_ch.present_flags,
                 rsp_ch.frame_flags, rsp_ch.data_rate, rsp_ch.frequency,
                 rsp_ch.channel_flags, rsp_ch.mcs_known, rsp_ch.mcs_flags,
                 rsp_ch.mcs_index};
         if (parse_results.size() == 0) begin
            note_error("result with no packet end pending");
         end else begin
            want = parse_results.pop_front();
            results_checked++;
            compare_field("length_ok", 32'(got.length_ok), 32'(want.length_ok));
            compare_field("header_length", 32'(got.header_length),
                          32'(want.header_length));
            compare_field("present_flags", got.present_flags, want.present_flags);
            compare_field("frame_flags", 32'(got.frame_flags), 32'(want.frame_flags));
            compare_field("data_rate", 32'(got.data_rate), 32'(want.data_rate));
            compare_field("frequency", 32'(got.frequency), 32'(want.frequency));
            compare_field("channel_flags", 32'(got.channel_flags),
                          32'(want.channel_flags));
            compare_field("mcs_known", 32'(got.mcs_known), 32'(want.mcs_known));
            compare_field("mcs_flags", 32'(got.mcs_flags), 32'(want.mcs_flags));
            compare_field("mcs_index", 32'(got.mcs_index), 32'(want.mcs_index));
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin : watchdog
      if (reset || csr_psel || (req_ch.valid && req_ch.ready)
          || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
         $display("no handshake for %0d cycles, %0d results outstanding",
                  idle_cycles, parse_results.size());
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
